[hw/rtl/jsu_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// jsu_pkg - shared types and helpers for the JSON string unescaper
// Result kinds, error codes, scan modes and the hex / escape lookups.
// ---------------------------------------------------------------------------
package jsu_pkg;

  localparam int BYTE_W = 8;
  localparam int KIND_W = 2;
  localparam int ERR_W  = 3;
  localparam int USER_W = KIND_W + ERR_W;
  localparam int MAX_RES = 3;

  localparam logic [KIND_W-1:0] KIND_BYTE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DONE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

  localparam logic [ERR_W-1:0] ERR_NONE         = 3'd0;
  localparam logic [ERR_W-1:0] ERR_NO_QUOTE     = 3'd1;
  localparam logic [ERR_W-1:0] ERR_CTRL_CHAR    = 3'd2;
  localparam logic [ERR_W-1:0] ERR_INC_ESCAPE   = 3'd3;
  localparam logic [ERR_W-1:0] ERR_INC_UNICODE  = 3'd4;
  localparam logic [ERR_W-1:0] ERR_BAD_HEX      = 3'd5;
  localparam logic [ERR_W-1:0] ERR_BAD_ESCAPE   = 3'd6;
  localparam logic [ERR_W-1:0] ERR_UNTERMINATED = 3'd7;

  localparam logic [BYTE_W-1:0] CH_QUOTE     = 8'h22;
  localparam logic [BYTE_W-1:0] CH_BACKSLASH = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_U         = 8'h75;
  localparam logic [BYTE_W-1:0] CH_SPACE     = 8'h20;

  localparam logic [BYTE_W-1:0] UTF8_LEAD2 = 8'hC0;
  localparam logic [BYTE_W-1:0] UTF8_LEAD3 = 8'hE0;
  localparam logic [BYTE_W-1:0] UTF8_CONT  = 8'h80;

  typedef enum logic [3:0] {
    MODE_IDLE = 4'b0001,
    MODE_TEXT = 4'b0010,
    MODE_ESC  = 4'b0100,
    MODE_HEX  = 4'b1000
  } mode_t;

  // {valid, nibble}
  function automatic logic [4:0] hex_value(input logic [BYTE_W-1:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  // {valid, byte}
  function automatic logic [BYTE_W:0] escape_byte(input logic [BYTE_W-1:0] c);
    logic [BYTE_W:0] r;
    case (c)
      8'h22: r = {1'b1, 8'h22};
      8'h5C: r = {1'b1, 8'h5C};
      8'h2F: r = {1'b1, 8'h2F};
      8'h62: r = {1'b1, 8'h08};
      8'h66: r = {1'b1, 8'h0C};
      8'h6E: r = {1'b1, 8'h0A};
      8'h72: r = {1'b1, 8'h0D};
      8'h74: r = {1'b1, 8'h09};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/json_string_unescaper_unit.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// json_string_unescaper_unit - JSON string literal to UTF-8 byte stream
// Decodes one quoted literal per run: plain bytes, simple escapes, \uXXXX
// escapes as 1..3 UTF-8 bytes, a done marker at the closing quote, errors.
// ---------------------------------------------------------------------------
//  channel  dir  tdata            tuser                          tlast
//  s_*      in   data_byte[7:0]   source_ended[0]                -
//  m_*      out  out_byte[7:0]    result_kind[1:0],error_code[4:2] last_of_run
//
// One source byte is taken per cycle, while the buffer has room, into an input
// register, decoded in one pass and loaded into a three-entry result buffer that
// drains one result a cycle while m_tready is high. Bytes with one or no result
// sustain one per cycle; a multi-byte \u escape holds the next byte at the buffer.
// Reset is synchronous and returns the scanner to idle with both buffers empty.
// ---------------------------------------------------------------------------
module json_string_unescaper_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [jsu_pkg::BYTE_W-1:0] s_tdata,   // [7:0] data_byte
  input  logic                       s_tuser,   // [0] source_ended
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [jsu_pkg::BYTE_W-1:0] m_tdata,   // [7:0] out_byte
  output logic [jsu_pkg::USER_W-1:0] m_tuser,   // [1:0] result_kind, [4:2] error_code
  output logic                       m_tlast    // last_of_run
);
  import jsu_pkg::*;

  // input register
  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              in_end;

  // scanner state
  mode_t       mode, mode_next;
  logic [1:0]  hex_cnt, hex_cnt_next;
  logic [15:0] code_pt, code_pt_next;

  // result buffer
  logic [BYTE_W-1:0] res_byte [MAX_RES];
  logic [KIND_W-1:0] res_kind [MAX_RES];
  logic [ERR_W-1:0]  res_err  [MAX_RES];
  logic [1:0]        left;
  logic [1:0]        hd;

  // decode outputs
  logic [1:0]        k;
  logic [BYTE_W-1:0] d_byte [MAX_RES];
  logic [KIND_W-1:0] d_kind [MAX_RES];
  logic [ERR_W-1:0]  d_err;
  logic              fail;
  logic [4:0]        hv;
  logic [BYTE_W:0]   ev;
  logic [15:0]       cp_full;

  logic pop, buf_free, consume;

  assign pop      = m_tvalid && m_tready;
  assign buf_free = (left == 2'd0) || (left == 2'd1 && m_tready);
  assign consume  = in_valid && buf_free;
  assign s_tready = !in_valid || buf_free;

  assign m_tvalid = (left != 2'd0);
  assign m_tdata  = res_byte[hd];
  assign m_tuser  = {res_err[hd], res_kind[hd]};
  assign m_tlast  = (left == 2'd1);

  assign hv      = hex_value(in_byte);
  assign ev      = escape_byte(in_byte);
  assign cp_full = {code_pt[11:0], hv[3:0]};

  always_comb begin
    k            = 2'd0;
    fail         = 1'b0;
    d_err        = ERR_NONE;
    mode_next    = mode;
    hex_cnt_next = hex_cnt;
    code_pt_next = code_pt;
    for (int i = 0; i < MAX_RES; i++) begin
      d_byte[i] = '0;
      d_kind[i] = KIND_BYTE;
    end
    case (mode)
      MODE_IDLE: begin
        if (!in_end) begin
          if (in_byte == CH_QUOTE) begin
            mode_next    = MODE_TEXT;
            hex_cnt_next = 2'd0;
            code_pt_next = 16'd0;
          end else begin
            fail  = 1'b1;
            d_err = ERR_NO_QUOTE;
          end
        end
      end
      MODE_TEXT: begin
        if (in_end) begin
          fail  = 1'b1;
          d_err = ERR_UNTERMINATED;
        end else if (in_byte == CH_QUOTE) begin
          mode_next = MODE_IDLE;
          k         = 2'd1;
          d_kind[0] = KIND_DONE;
        end else if (in_byte == CH_BACKSLASH) begin
          mode_next = MODE_ESC;
        end else if (in_byte < CH_SPACE) begin
          fail  = 1'b1;
          d_err = ERR_CTRL_CHAR;
        end else begin
          k         = 2'd1;
          d_byte[0] = in_byte;
        end
      end
      MODE_ESC: begin
        if (in_end) begin
          fail  = 1'b1;
          d_err = ERR_INC_ESCAPE;
        end else if (in_byte == CH_U) begin
          mode_next    = MODE_HEX;
          hex_cnt_next = 2'd0;
          code_pt_next = 16'd0;
        end else if (!ev[BYTE_W]) begin
          fail  = 1'b1;
          d_err = ERR_BAD_ESCAPE;
        end else begin
          mode_next = MODE_TEXT;
          k         = 2'd1;
          d_byte[0] = ev[BYTE_W-1:0];
        end
      end
      MODE_HEX: begin
        if (in_end) begin
          fail  = 1'b1;
          d_err = ERR_INC_UNICODE;
        end else if (!hv[4]) begin
          fail  = 1'b1;
          d_err = ERR_BAD_HEX;
        end else if (hex_cnt == 2'd3) begin
          mode_next    = MODE_TEXT;
          hex_cnt_next = 2'd0;
          code_pt_next = 16'd0;
          if (cp_full[15:7] == '0) begin
            k         = 2'd1;
            d_byte[0] = {1'b0, cp_full[6:0]};
          end else if (cp_full[15:11] == '0) begin
            k         = 2'd2;
            d_byte[0] = UTF8_LEAD2 | {3'b000, cp_full[10:6]};
            d_byte[1] = UTF8_CONT | {2'b00, cp_full[5:0]};
          end else begin
            k         = 2'd3;
            d_byte[0] = UTF8_LEAD3 | {4'b0000, cp_full[15:12]};
            d_byte[1] = UTF8_CONT | {2'b00, cp_full[11:6]};
            d_byte[2] = UTF8_CONT | {2'b00, cp_full[5:0]};
          end
        end else begin
          hex_cnt_next = hex_cnt + 2'd1;
          code_pt_next = cp_full;
        end
      end
      default: begin
        mode_next = MODE_IDLE;
      end
    endcase
    if (fail) begin
      mode_next    = MODE_IDLE;
      hex_cnt_next = 2'd0;
      code_pt_next = 16'd0;
      k            = 2'd1;
      d_kind[0]    = KIND_ERROR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_end  <= s_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_IDLE;
      hex_cnt <= 2'd0;
      code_pt <= 16'd0;
    end else if (consume) begin
      mode    <= mode_next;
      hex_cnt <= hex_cnt_next;
      code_pt <= code_pt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left <= 2'd0;
      hd   <= 2'd0;
    end else if (consume) begin
      left <= k;
      hd   <= 2'd0;
    end else if (pop) begin
      left <= left - 2'd1;
      hd   <= hd + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && k != 2'd0) begin
      for (int i = 0; i < MAX_RES; i++) begin
        res_byte[i] <= d_byte[i];
        res_kind[i] <= d_kind[i];
        res_err[i]  <= (i == 0) ? d_err : ERR_NONE;
      end
    end
  end

  // buffer is only reloaded once the last pending result leaves
  a_reload_free: assert property (@(posedge clk) disable iff (rst)
    consume |-> (left == 2'd0 || (left == 2'd1 && pop)))
    else $error("result buffer reloaded while results pending");

  // an error always drops the scanner back to idle
  a_err_idle: assert property (@(posedge clk) disable iff (rst)
    (consume && fail) |=> (mode == MODE_IDLE && hex_cnt == 2'd0))
    else $error("scanner not idle after error");

  a_hex_cnt_mode: assert property (@(posedge clk) disable iff (rst)
    (hex_cnt != 2'd0) |-> (mode == MODE_HEX))
    else $error("hex digit count outside unicode escape");

  a_err_kind: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[KIND_W-1:0] != KIND_ERROR) |-> (m_tuser[USER_W-1:KIND_W] == ERR_NONE))
    else $error("error code on non-error result");

  a_read_ptr: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ({1'b0, hd} + {1'b0, left} <= 3'(MAX_RES)))
    else $error("result read pointer past loaded entries");

endmodule
